@@ design/lfx_pkg.sv @@
// ----------------------------------------------------------------------------
// lfx_pkg: shared types and constants of the LED frame effect engine
// Word layouts, command and effect codes, register indexes, and the
// controller/datapath command and status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package lfx_pkg;

  // command codes
  localparam logic [1:0] CMD_SET_ONE = 2'd0;
  localparam logic [1:0] CMD_SET_ALL = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;
  localparam logic [1:0] CMD_EFFECT  = 2'd3;

  // effect codes (effect_select mod 5)
  localparam logic [2:0] EFF_OFF     = 3'd0;
  localparam logic [2:0] EFF_SUNRISE = 3'd1;
  localparam logic [2:0] EFF_SUNSET  = 3'd2;
  localparam logic [2:0] EFF_ON      = 3'd3;
  localparam logic [2:0] EFF_MANUAL  = 3'd4;

  localparam logic [7:0] SUN_LOW  = 8'd51;
  localparam logic [7:0] SUN_HIGH = 8'd204;
  localparam logic [7:0] CH_MAX   = 8'd255;

  localparam logic [12:0] DELAY_STEP   = 13'd1;
  localparam logic [12:0] DELAY_SUN    = 13'd6000;
  localparam logic [12:0] DELAY_MANUAL = 13'd5;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_SHIFT   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_SHIFT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_SHIFT  = 8'd3;

  localparam logic [8:0] RST_LED_COUNT   = 9'd256;
  localparam logic [4:0] RST_RED_SHIFT   = 5'd8;
  localparam logic [4:0] RST_GREEN_SHIFT = 5'd16;
  localparam logic [4:0] RST_BLUE_SHIFT  = 5'd0;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] led_index;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] effect_select;
  } lfx_in_t;

  typedef struct packed {
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [23:0] wire_word;
    logic [12:0] delay_ticks;
    logic        status;
  } lfx_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic cnt_clr;
    logic clr_wr;
    logic fill_wr;
    logic set_wr;
    logic rd_idx;
    logic rd_walk;
    logic load_out;
  } lfx_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] command;
    logic       idx_ok;
    logic       n_zero;
    logic       cnt_last;
    logic       clr_last;
    logic       wb_pend;
  } lfx_sts_t;

endpackage

`default_nettype wire

@@ design/lfx_datapath.sv @@
// ----------------------------------------------------------------------------
// lfx_datapath: frame store, LED counter, effect logic and result register
// Holds the config registers and the current command word, walks the
// frame store one LED per cycle on command of the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module lfx_datapath #(
  parameter int unsigned MAX_LEDS = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire lfx_pkg::lfx_cmd_t               cmd,
  output lfx_pkg::lfx_sts_t                    sts,
  input  wire lfx_pkg::lfx_in_t                in_data,
  output lfx_pkg::lfx_out_t                    out_data,
  input  wire logic                            cfg_wr,
  input  wire logic [lfx_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lfx_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int unsigned CW = $clog2(MAX_LEDS + 1);
  localparam int unsigned LW = (CW > 9) ? CW : 9;

  // config registers
  logic [8:0] led_count_r;
  logic [4:0] red_shift_r, green_shift_r, blue_shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r   <= lfx_pkg::RST_LED_COUNT;
      red_shift_r   <= lfx_pkg::RST_RED_SHIFT;
      green_shift_r <= lfx_pkg::RST_GREEN_SHIFT;
      blue_shift_r  <= lfx_pkg::RST_BLUE_SHIFT;
    end else if (cfg_wr) begin
      case (cfg_index)
        lfx_pkg::REG_LED_COUNT:   led_count_r   <= cfg_data[8:0];
        lfx_pkg::REG_RED_SHIFT:   red_shift_r   <= cfg_data[4:0];
        lfx_pkg::REG_GREEN_SHIFT: green_shift_r <= cfg_data[4:0];
        lfx_pkg::REG_BLUE_SHIFT:  blue_shift_r  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // LEDs in use
  logic [CW-1:0] n;
  always_comb begin
    if (LW'(led_count_r) > LW'(MAX_LEDS)) n = CW'(MAX_LEDS);
    else                                  n = CW'(led_count_r);
  end

  // effect_select mod 5; 16 = 1 mod 5 so nibble sums keep the residue
  logic [4:0] s1, s2;
  logic [2:0] eff_nxt;
  always_comb begin
    s1 = 5'(in_data.effect_select[7:4]) + 5'(in_data.effect_select[3:0]);
    s2 = 5'(s1[4]) + 5'(s1[3:0]);
    if (s2 >= 5'd10) s2 = s2 - 5'd10;
    if (s2 >= 5'd5)  s2 = s2 - 5'd5;
    eff_nxt = s2[2:0];
  end

  // current command word
  logic [1:0]  command_r;
  logic [7:0]  idx_r;
  logic [23:0] rgb_r;
  logic [2:0]  eff_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      command_r <= in_data.command;
      idx_r     <= in_data.led_index;
      rgb_r     <= {in_data.red_in, in_data.green_in, in_data.blue_in};
      eff_r     <= eff_nxt;
    end
  end

  logic idx_ok;
  assign idx_ok = LW'(idx_r) < LW'(n);

  // LED counter
  logic [CW-1:0] cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.clr_wr || cmd.fill_wr || cmd.rd_walk) begin
      cnt_r <= CW'(cnt_r + 1'b1);
    end
  end

  // effect walk: read at cnt, write back the next cycle
  logic          wb_pend_r;
  logic [AW-1:0] wb_addr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) wb_pend_r <= 1'b0;
    else        wb_pend_r <= cmd.rd_walk;
  end
  always_ff @(posedge clk) begin
    if (cmd.rd_walk) wb_addr_r <= cnt_r[AW-1:0];
  end

  function automatic logic [23:0] led_effect(input logic [2:0] eff, input logic [23:0] rgb);
    logic [7:0] r, g, b;
    r = rgb[23:16];
    g = rgb[15:8];
    b = rgb[7:0];
    case (eff)
      lfx_pkg::EFF_OFF: begin
        if (r != 8'd0) r = r - 8'd1;
        if (g != 8'd0) g = g - 8'd1;
        if (b != 8'd0) b = b - 8'd1;
      end
      lfx_pkg::EFF_SUNRISE: begin
        if (r != lfx_pkg::CH_MAX) r = r + 8'd1;
        if (r > lfx_pkg::SUN_LOW && g != lfx_pkg::CH_MAX) g = g + 8'd1;
        if (r > lfx_pkg::SUN_LOW && g > lfx_pkg::SUN_LOW && b != lfx_pkg::CH_MAX)
          b = b + 8'd1;
      end
      lfx_pkg::EFF_SUNSET: begin
        if (b != 8'd0) b = b - 8'd1;
        if (b < lfx_pkg::SUN_HIGH && g != 8'd0) g = g - 8'd1;
        if (b < lfx_pkg::SUN_HIGH && g < lfx_pkg::SUN_HIGH && r != 8'd0) r = r - 8'd1;
      end
      lfx_pkg::EFF_ON: begin
        if (r != lfx_pkg::CH_MAX) r = r + 8'd1;
        if (g != lfx_pkg::CH_MAX) g = g + 8'd1;
        if (b != lfx_pkg::CH_MAX) b = b + 8'd1;
      end
      default: ;
    endcase
    return {r, g, b};
  endfunction

  // frame store, {red, green, blue} per LED
  logic [23:0]   mem [MAX_LEDS];
  logic [23:0]   rdata_r;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [23:0]   wdata;

  always_comb begin
    we    = 1'b0;
    waddr = cnt_r[AW-1:0];
    wdata = rgb_r;
    if (cmd.clr_wr) begin
      we    = 1'b1;
      wdata = '0;
    end else if (cmd.fill_wr) begin
      we = 1'b1;
    end else if (cmd.set_wr) begin
      we    = 1'b1;
      waddr = AW'(idx_r);
    end else if (wb_pend_r) begin
      we    = 1'b1;
      waddr = wb_addr_r;
      wdata = led_effect(eff_r, rdata_r);
    end
    re    = cmd.rd_idx || cmd.rd_walk;
    raddr = cmd.rd_idx ? AW'(idx_r) : cnt_r[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  // result word
  lfx_pkg::lfx_out_t res;
  lfx_pkg::lfx_out_t out_r;

  always_comb begin
    res = '0;
    case (command_r)
      lfx_pkg::CMD_SET_ONE: res.status = !idx_ok;
      lfx_pkg::CMD_READ: begin
        res.status = !idx_ok;
        if (idx_ok) begin
          res.red_out   = rdata_r[23:16];
          res.green_out = rdata_r[15:8];
          res.blue_out  = rdata_r[7:0];
          res.wire_word = (24'(rdata_r[23:16]) << red_shift_r)
                        | (24'(rdata_r[15:8]) << green_shift_r)
                        | (24'(rdata_r[7:0]) << blue_shift_r);
        end
      end
      lfx_pkg::CMD_EFFECT: begin
        if (eff_r == lfx_pkg::EFF_SUNRISE || eff_r == lfx_pkg::EFF_SUNSET)
          res.delay_ticks = lfx_pkg::DELAY_SUN;
        else if (eff_r == lfx_pkg::EFF_MANUAL)
          res.delay_ticks = lfx_pkg::DELAY_MANUAL;
        else
          res.delay_ticks = lfx_pkg::DELAY_STEP;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) out_r <= res;
  end

  assign out_data = out_r;

  assign sts.command  = command_r;
  assign sts.idx_ok   = idx_ok;
  assign sts.n_zero   = (n == '0);
  assign sts.cnt_last = (CW'(cnt_r + 1'b1) == n);
  assign sts.clr_last = (cnt_r == CW'(MAX_LEDS - 1));
  assign sts.wb_pend  = wb_pend_r;

endmodule

`default_nettype wire

@@ design/lfx_ctrl.sv @@
// ----------------------------------------------------------------------------
// lfx_ctrl: sequencer of the LED frame effect engine
// Runs the clearing pass after reset, then takes one word at a time and
// steps the datapath through set, fill, read or effect walk.
// ----------------------------------------------------------------------------
`default_nettype none

module lfx_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire lfx_pkg::lfx_sts_t sts,
  output lfx_pkg::lfx_cmd_t      cmd
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_FILL  = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.cnt_clr = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_DONE;
        case (sts.command)
          lfx_pkg::CMD_SET_ONE: cmd.set_wr = sts.idx_ok;
          lfx_pkg::CMD_SET_ALL: if (!sts.n_zero) state_nxt = ST_FILL;
          lfx_pkg::CMD_READ:    cmd.rd_idx = sts.idx_ok;
          lfx_pkg::CMD_EFFECT:  if (!sts.n_zero) state_nxt = ST_WALK;
          default: ;
        endcase
      end
      ST_FILL: begin
        cmd.fill_wr = 1'b1;
        if (sts.cnt_last) state_nxt = ST_DONE;
      end
      ST_WALK: begin
        cmd.rd_walk = 1'b1;
        if (sts.cnt_last) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: state_nxt = ST_DONE;   // last write-back lands here
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out)          out_valid_nxt = 1'b1;
    else if (out_ready)        out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_load_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result word overwritten while still pending");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !out_valid_r)
    else $error("result presented during clearing pass");

  a_flush_wb: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FLUSH |-> sts.wb_pend)
    else $error("walk ended without pending write-back");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK || state_r == ST_FILL) |-> !sts.n_zero)
    else $error("walk started with no LEDs in use");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == ST_EXEC)
    else $error("accepted word not dispatched");

endmodule

`default_nettype wire

@@ design/rgb_led_frame_effect_engine.sv @@
// ----------------------------------------------------------------------------
// rgb_led_frame_effect_engine: RGB LED strip frame store with fade effects
// Top level: controller plus datapath, config port always ready.
// ----------------------------------------------------------------------------
// Usage:
//  in_valid/in_ready carry one command word (set one, set all, read one,
//  effect step); out_valid/out_ready return exactly one result word each.
//  cfg_valid/cfg_ready write led_count and the three channel shifts by
//  index; cfg_ready is always high. Writes go in while the block is idle:
//  the user is bound to this, the block itself does not enforce it.
//  The frame store has one read and one write port, and the walk
//  handles one LED per cycle. A new word is taken in the cycle after
//  the previous result is loaded.
//  Reset: a clearing pass zeroes every entry of the store, with in_ready
//  low. If the receiver stalls, the finished word waits in the output
//  register; the next word is accepted and worked, and its result waits
//  until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_led_frame_effect_engine #(
  parameter int unsigned MAX_LEDS = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire lfx_pkg::lfx_in_t                in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output lfx_pkg::lfx_out_t                    out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lfx_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lfx_pkg::CFG_DATA_W-1:0]  cfg_data
);

  lfx_pkg::lfx_cmd_t cmd;
  lfx_pkg::lfx_sts_t sts;

  assign cfg_ready = 1'b1;

  lfx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lfx_datapath #(
    .MAX_LEDS (MAX_LEDS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire
